### hdl/ptc_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the collision unit.
package ptc_pkg;

    localparam int GAIN_FRAC = 16;
    localparam logic [19:0] LATE_SCALE = 20'd1000000;
    localparam logic [18:0] GAIN_ONE = 19'd65536;

    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_TGAIN = 2'd1;
    localparam logic [1:0] REG_RGAIN = 2'd2;

    typedef logic signed [31:0] t_word;
    typedef logic signed [63:0] t_wide;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SKIP,
        K_PART
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  slot;
        logic [1:0]  vsel;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic [31:0] dt;
    } t_item;

    typedef struct packed {
        logic [6:0]  count;
        logic [17:0] tgain;
        logic [17:0] rgain;
    } t_cfg;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [3:0]  bounces;
        logic [5:0]  last;
        logic        hit;
        logic        capped;
    } t_result;

    typedef enum logic [4:0] {
        B_IDLE, B_LOAD, B_SINIT, B_FETCH, B_F0, B_MV, B_F1, B_VN,
        B_DCAP, B_DIT, B_DFIN, B_XI, B_C, B_DEN, B_XA, B_NA,
        B_XB, B_NB, B_LATE, B_UPD, B_NEXT, B_SDONE, B_S, B_TMP,
        B_VT, B_VR, B_PU, B_OUT
    } t_bstate;

    function automatic t_word sat32(input t_wide v);
        t_word r;
        if (v > 64'sd2147483647) r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic t_word add32(input t_word a, input t_word b);
        t_wide s;
        s = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
        return sat32(s);
    endfunction

    function automatic t_word sub32(input t_word a, input t_word b);
        t_wide s;
        s = $signed({{32{a[31]}}, a}) - $signed({{32{b[31]}}, b});
        return sat32(s);
    endfunction

    function automatic t_wide sadd64(input t_wide a, input t_wide b);
        logic signed [64:0] s;
        t_wide r;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63]) r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else r = s[63:0];
        return r;
    endfunction

    function automatic logic [63:0] abs64(input t_wide v);
        logic [63:0] r;
        r = v[63] ? (~v + 64'd1) : v;
        return r;
    endfunction

    function automatic logic [31:0] abs32(input t_word v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

### hdl/particle_triangle_collision_unit.sv
// A particle beat's run time grows with its bounces and with the triangle count, and is
// set by the single shared 32x32 multiplier and the one-bit-a-cycle divider.
// Throughput: one beat at a time in the engine; a two-entry queue keeps the input open.
// Reset: synchronous, active low; count resets to 0, both gains to 1.0.
// The triangle memory is not cleared and holds whatever was last loaded.
module particle_triangle_collision_unit #(
    parameter int MAX_TRIANGLES = 64,
    parameter int MAX_BOUNCES   = 8,
    parameter int FRAC_BITS     = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tri_index, vector_select, ax, ay, az, bx, by, bz, step_time
    input  logic [231:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    // bounce_count, last_triangle, hit_flag, bounce_limit_hit, zero pad
    output logic [207:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ptc_pkg::*;

    t_cfg    r_cfg;
    t_item   f_item, q_item;
    logic    f_valid, q_ready, q_valid, pop;
    t_result res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count <= '0;
            r_cfg.tgain <= GAIN_ONE[17:0];
            r_cfg.rgain <= GAIN_ONE[17:0];
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_COUNT: r_cfg.count <= pwdata[6:0];
                REG_TGAIN: r_cfg.tgain <= pwdata[17:0];
                REG_RGAIN: r_cfg.rgain <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COUNT: prdata = {25'b0, r_cfg.count};
            REG_TGAIN: prdata = {14'b0, r_cfg.tgain};
            REG_RGAIN: prdata = {14'b0, r_cfg.rgain};
            default:   prdata = '0;
        endcase
    end

    ptc_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_user  (s_tuser[0]),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_ready (q_ready)
    );

    ptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    ptc_back #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .MAX_BOUNCES   (MAX_BOUNCES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .i_cfg    (r_cfg),
        .o_valid  (m_tvalid),
        .o_result (res),
        .i_ready  (m_tready)
    );

    assign m_tdata = {4'b0, res.capped, res.hit, res.last, res.bounces,
                      res.vel_z, res.vel_y, res.vel_x, res.pos_z, res.pos_y, res.pos_x};

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("engine took a beat from an empty queue");

    a_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !res.hit) |-> (res.bounces == 4'd0 && res.last == 6'd0 && !res.capped))
        else $error("result without a hit carries bounce data");

    a_cap_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && res.capped) |-> res.hit) else $error("bounce cap without a hit");

endmodule

### hdl/ptc_front.sv
// Input stage: takes stream beats, unpacks and classifies them for the queue.
module ptc_front #(
    parameter int MAX_TRIANGLES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [231:0]      i_data,
    input  logic              i_user,
    output logic              o_valid,
    output ptc_pkg::t_item    o_item,
    input  logic              i_ready
);
    import ptc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.slot = i_data[5:0];
        n_item.vsel = i_data[7:6];
        n_item.ax   = i_data[39:8];
        n_item.ay   = i_data[71:40];
        n_item.az   = i_data[103:72];
        n_item.bx   = i_data[135:104];
        n_item.by   = i_data[167:136];
        n_item.bz   = i_data[199:168];
        n_item.dt   = i_data[231:200];
        if (i_user) n_item.kind = K_PART;
        else if (32'(i_data[5:0]) < MAX_TRIANGLES) n_item.kind = K_LOAD;
        else n_item.kind = K_SKIP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/ptc_queue.sv
// Two-entry queue between the input stage and the collision engine.
module ptc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_ready,
    input  ptc_pkg::t_item    i_item,
    output logic              o_valid,
    output ptc_pkg::t_item    o_item,
    input  logic              i_pop
);
    import ptc_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok) r_rp <= !r_rp;
            if (push_ok && !pop_ok) r_cnt <= r_cnt + 2'd1;
            else if (pop_ok && !push_ok) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= i_item;
    end

endmodule

### hdl/ptc_back.sv
// Collision engine: triangle memory, shared multiplier, serial divider and sequencer.
module ptc_back #(
    parameter int MAX_TRIANGLES = 64,
    parameter int MAX_BOUNCES   = 8,
    parameter int FRAC_BITS     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptc_pkg::t_item    i_item,
    output logic              o_pop,
    input  ptc_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output ptc_pkg::t_result  o_result,
    input  logic              i_ready
);
    import ptc_pkg::*;

    localparam int DEPTH = MAX_TRIANGLES * 12;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_TRIANGLES + 1);
    localparam int BW    = $clog2(MAX_BOUNCES + 1);
    localparam int NW    = 64 + FRAC_BITS;
    localparam int CW    = NW + 31;

    t_bstate r_state, n_state;
    logic [4:0] r_k, n_k;
    logic r_ph, n_ph;

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic [5:0] r_slot;
    logic [1:0] r_sel;
    t_word r_pos [3];
    t_word r_vel [3];
    t_word r_dt;
    t_word r_tri [12];
    t_word r_tmp [3];
    t_word r_xi [3];
    t_word r_d [3];
    t_word r_c [3];
    t_word r_x [3];
    t_word r_ga [3];
    t_word r_dti;
    t_word r_s;
    t_wide r_acc;
    t_wide r_prod;
    t_wide r_f0;
    t_wide r_vn;
    t_wide r_den;
    t_wide r_na;
    logic [63:0] r_rem;
    logic [30:0] r_nlo;
    logic [30:0] r_q;
    logic r_qcap;
    logic [51:0] r_late;

    logic r_found;
    logic [TW-1:0] r_bt;
    t_word r_bdti;
    t_word r_bxi [3];
    t_word r_bn [3];
    logic [TW-1:0] r_t;
    logic [TW-1:0] r_cnt;
    logic [AW-1:0] r_base;
    logic [BW-1:0] r_bounces;
    logic [TW-1:0] r_last;
    logic r_hit;
    logic r_capped;

    logic r_mvalid;
    t_result r_res;

    t_word p0 [3];
    t_word e1 [3];
    t_word e2 [3];
    t_word nv [3];
    t_word ma, mb;
    logic [1:0] ii, jj;
    logic mm;
    t_wide dot_sum, cross_sum;
    t_word qf, qg, cross_c, dot_c;
    logic [63:0] dvd;
    logic [NW-1:0] nn;
    logic cap;
    logic [64:0] r2;
    logic [31:0] adt, adti;
    logic late_bad;
    logic last_tri;
    logic [TW-1:0] cnt_lim;
    t_wide qv;
    logic mul_st, mul_last;
    t_bstate tgt;
    t_wide s_nb;

    function automatic logic [1:0] rot1(input logic [1:0] j);
        logic [1:0] r;
        case (j)
            2'd0: r = 2'd1;
            2'd1: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] rot2(input logic [1:0] j);
        logic [1:0] r;
        case (j)
            2'd0: r = 2'd2;
            2'd1: r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    assign ii = r_k[1:0];
    assign jj = r_k[2:1];
    assign mm = r_k[0];

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            p0[x] = r_tri[x];
            e1[x] = r_tri[x + 3];
            e2[x] = r_tri[x + 6];
            nv[x] = r_tri[x + 9];
        end
    end

    assign dot_sum   = (r_k == 5'd0) ? r_prod : sadd64(r_acc, r_prod);
    assign cross_sum = sadd64(r_acc, -r_prod);
    assign qf        = sat32(r_prod >>> FRAC_BITS);
    assign qg        = sat32(r_prod >>> GAIN_FRAC);
    assign cross_c   = sat32(cross_sum >>> FRAC_BITS);
    assign dot_c     = sat32(dot_sum >>> FRAC_BITS);
    assign s_nb      = sadd64(r_na, dot_sum);

    assign dvd  = abs64(r_vn);
    assign nn   = {abs64(r_f0), {FRAC_BITS{1'b0}}};
    assign cap  = (CW'(nn) >= CW'({dvd, 31'b0}));
    assign r2   = {r_rem, r_nlo[30]};
    assign qv   = r_qcap ? 64'sh80000000 : $signed({33'b0, r_q});

    assign adt  = abs32(r_dt);
    assign adti = abs32(r_dti);
    assign late_bad = (r_dt[31] && !r_dti[31] && r_dti != 0)
                   || (!r_dt[31] && r_dt != 0 && r_dti[31]) || (adti > adt);
    assign last_tri = (32'(r_t) + 32'd1 >= 32'(r_cnt));
    assign cnt_lim  = (32'(i_cfg.count) > MAX_TRIANGLES) ? TW'(MAX_TRIANGLES)
                                                         : TW'(i_cfg.count);

    assign rd_addr = AW'(32'(r_base) + 32'(r_k));
    assign wr_addr = AW'(32'(r_slot) * 12 + 32'(r_sel) * 3 + 32'(r_k));

    // multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            B_F0: begin ma = sub32(r_pos[ii], p0[ii]); mb = nv[ii]; end
            B_MV: begin ma = r_vel[ii]; mb = r_dt; end
            B_F1: begin ma = sub32(sub32(r_pos[ii], r_tmp[ii]), p0[ii]); mb = nv[ii]; end
            B_VN: begin ma = r_vel[ii]; mb = nv[ii]; end
            B_XI: begin ma = r_vel[ii]; mb = r_dti; end
            B_C: begin
                ma = mm ? e1[rot2(jj)] : e1[rot1(jj)];
                mb = mm ? e2[rot1(jj)] : e2[rot2(jj)];
            end
            B_DEN: begin ma = r_c[ii]; mb = r_c[ii]; end
            B_XA: begin
                ma = mm ? r_d[rot2(jj)] : r_d[rot1(jj)];
                mb = mm ? e2[rot1(jj)] : e2[rot2(jj)];
            end
            B_XB: begin
                ma = mm ? e1[rot2(jj)] : e1[rot1(jj)];
                mb = mm ? r_d[rot1(jj)] : r_d[rot2(jj)];
            end
            B_NA, B_NB: begin ma = r_c[ii]; mb = r_x[ii]; end
            B_S: begin ma = r_bn[ii]; mb = r_vel[ii]; end
            B_TMP: begin ma = r_bn[ii]; mb = r_s; end
            B_VT: begin ma = sub32(r_vel[ii], r_tmp[ii]); mb = {14'b0, i_cfg.tgain}; end
            B_VR: begin ma = r_tmp[ii]; mb = {14'b0, i_cfg.rgain}; end
            B_PU: begin ma = r_vel[ii]; mb = r_bdti; end
            default: ;
        endcase
    end

    assign o_pop = (r_state == B_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ph    <= n_ph;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_ph     = r_ph;
        mul_st   = 1'b0;
        mul_last = 1'b0;
        tgt      = r_state;
        case (r_state)
            B_IDLE: begin
                n_k = '0;
                if (i_valid) begin
                    case (i_item.kind)
                        K_LOAD: n_state = B_LOAD;
                        K_PART: n_state = B_SINIT;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_LOAD: begin
                if (r_k == 5'd2) begin
                    n_k = '0;
                    n_state = B_IDLE;
                end else n_k = r_k + 5'd1;
            end
            B_SINIT: begin
                n_k = '0;
                n_state = (cnt_lim == '0) ? B_SDONE : B_FETCH;
            end
            B_FETCH: begin
                if (r_k == 5'd12) begin
                    n_k = '0;
                    n_ph = 1'b0;
                    n_state = B_F0;
                end else n_k = r_k + 5'd1;
            end
            B_F0: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = (dot_sum == 0) ? B_NEXT : B_MV;
            end
            B_MV: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_F1; end
            B_F1: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = ((r_f0 > 0 && dot_sum > 0) || (r_f0 < 0 && dot_sum < 0))
                    ? B_NEXT : B_VN;
            end
            B_VN: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = (dot_sum == 0) ? B_NEXT : B_DCAP;
            end
            B_DCAP: begin
                n_k = '0;
                n_state = cap ? B_DFIN : B_DIT;
            end
            B_DIT: begin
                if (r_k == 5'd30) begin
                    n_k = '0;
                    n_state = B_DFIN;
                end else n_k = r_k + 5'd1;
            end
            B_DFIN: begin n_k = '0; n_ph = 1'b0; n_state = B_XI; end
            B_XI: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_C; end
            B_C: begin mul_st = 1'b1; mul_last = (r_k == 5'd5); tgt = B_DEN; end
            B_DEN: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = (dot_sum == 0) ? B_NEXT : B_XA;
            end
            B_XA: begin mul_st = 1'b1; mul_last = (r_k == 5'd5); tgt = B_NA; end
            B_NA: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = (dot_sum < 0 || dot_sum > r_den) ? B_NEXT : B_XB;
            end
            B_XB: begin mul_st = 1'b1; mul_last = (r_k == 5'd5); tgt = B_NB; end
            B_NB: begin
                mul_st = 1'b1; mul_last = (r_k == 5'd2);
                tgt = (dot_sum < 0 || dot_sum > r_den || s_nb < 0 || s_nb > r_den)
                    ? B_NEXT : B_LATE;
            end
            B_LATE: n_state = late_bad ? B_NEXT : B_UPD;
            B_UPD: n_state = B_NEXT;
            B_NEXT: begin
                n_k = '0;
                n_state = last_tri ? B_SDONE : B_FETCH;
            end
            B_SDONE: begin
                n_k = '0;
                n_ph = 1'b0;
                if (!r_found || 32'(r_bounces) >= MAX_BOUNCES) n_state = B_OUT;
                else n_state = B_S;
            end
            B_S: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_TMP; end
            B_TMP: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_VT; end
            B_VT: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_VR; end
            B_VR: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_PU; end
            B_PU: begin mul_st = 1'b1; mul_last = (r_k == 5'd2); tgt = B_SINIT; end
            B_OUT: begin
                if (!r_mvalid || i_ready) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
        if (mul_st) begin
            if (!r_ph) n_ph = 1'b1;
            else begin
                n_ph = 1'b0;
                if (mul_last) begin
                    n_k = '0;
                    n_state = tgt;
                end else n_k = r_k + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_LOAD) mem[wr_addr] <= r_pos[ii];
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!r_ph) r_prod <= ma * mb;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    r_slot <= i_item.slot;
                    r_sel  <= i_item.vsel;
                    r_pos[0] <= i_item.ax;
                    r_pos[1] <= i_item.ay;
                    r_pos[2] <= i_item.az;
                    r_vel[0] <= i_item.bx;
                    r_vel[1] <= i_item.by;
                    r_vel[2] <= i_item.bz;
                    r_dt <= i_item.dt;
                    r_bounces <= '0;
                    r_last <= '0;
                    r_hit <= 1'b0;
                    r_capped <= 1'b0;
                end
            end
            B_SINIT: begin
                r_found <= 1'b0;
                r_t <= '0;
                r_base <= '0;
                r_cnt <= cnt_lim;
            end
            B_FETCH: if (r_k != 5'd0) r_tri[r_k[3:0] - 4'd1] <= r_rd;
            B_F0: if (r_ph) begin
                r_acc <= dot_sum;
                r_f0 <= dot_sum;
            end
            B_MV: if (r_ph) r_tmp[ii] <= qf;
            B_F1: if (r_ph) r_acc <= dot_sum;
            B_VN: if (r_ph) begin
                r_acc <= dot_sum;
                r_vn <= dot_sum;
            end
            B_DCAP: begin
                r_qcap <= cap;
                r_rem <= 64'(nn >> 31);
                r_nlo <= nn[30:0];
                r_q <= '0;
            end
            B_DIT: begin
                if (r2 >= {1'b0, dvd}) begin
                    r_rem <= 64'(r2 - {1'b0, dvd});
                    r_q <= {r_q[29:0], 1'b1};
                end else begin
                    r_rem <= r2[63:0];
                    r_q <= {r_q[29:0], 1'b0};
                end
                r_nlo <= {r_nlo[29:0], 1'b0};
            end
            B_DFIN: r_dti <= sat32((r_f0[63] != r_vn[63]) ? -qv : qv);
            B_XI: if (r_ph) begin
                r_xi[ii] <= sub32(r_pos[ii], qf);
                r_d[ii] <= sub32(sub32(r_pos[ii], qf), p0[ii]);
            end
            B_C: if (r_ph) begin
                if (!mm) r_acc <= r_prod;
                else r_c[jj] <= cross_c;
            end
            B_DEN: if (r_ph) begin
                r_acc <= dot_sum;
                r_den <= dot_sum;
            end
            B_XA, B_XB: if (r_ph) begin
                if (!mm) r_acc <= r_prod;
                else r_x[jj] <= cross_c;
            end
            B_NA: if (r_ph) begin
                r_acc <= dot_sum;
                r_na <= dot_sum;
            end
            B_NB: if (r_ph) r_acc <= dot_sum;
            B_LATE: r_late <= 52'(adt - adti) * 52'(LATE_SCALE);
            B_UPD: begin
                if (!(r_late < 52'(adt)) && (!r_found || adti > abs32(r_bdti))) begin
                    r_found <= 1'b1;
                    r_bt <= r_t;
                    r_bdti <= r_dti;
                    for (int x = 0; x < 3; x++) begin
                        r_bxi[x] <= r_xi[x];
                        r_bn[x] <= nv[x];
                    end
                end
            end
            B_NEXT: begin
                r_t <= r_t + TW'(1);
                r_base <= AW'(32'(r_base) + 32'd12);
            end
            B_SDONE: if (r_found && 32'(r_bounces) >= MAX_BOUNCES) r_capped <= 1'b1;
            B_S: if (r_ph) begin
                r_acc <= dot_sum;
                r_s <= dot_c;
            end
            B_TMP: if (r_ph) r_tmp[ii] <= qf;
            B_VT: if (r_ph) r_ga[ii] <= qg;
            B_VR: if (r_ph) r_vel[ii] <= sub32(r_ga[ii], qg);
            B_PU: if (r_ph) begin
                r_pos[ii] <= add32(r_bxi[ii], qf);
                if (r_k == 5'd2) begin
                    r_dt <= r_bdti;
                    r_last <= r_bt;
                    r_hit <= 1'b1;
                    r_bounces <= r_bounces + BW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == B_OUT && (!r_mvalid || i_ready)) begin
            r_mvalid <= 1'b1;
        end else if (i_ready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_OUT && (!r_mvalid || i_ready)) begin
            r_res.pos_x   <= r_pos[0];
            r_res.pos_y   <= r_pos[1];
            r_res.pos_z   <= r_pos[2];
            r_res.vel_x   <= r_vel[0];
            r_res.vel_y   <= r_vel[1];
            r_res.vel_z   <= r_vel[2];
            r_res.bounces <= 4'(r_bounces);
            r_res.last    <= 6'(r_last);
            r_res.hit     <= r_hit;
            r_res.capped  <= r_capped;
        end
    end

    assign o_valid  = r_mvalid;
    assign o_result = r_res;

endmodule
